@@ src/parw_pkg.sv @@
// Shared types and constants for the per-peer anti-replay window.
package parw_pkg;

   localparam int PEER_COUNT_DEF  = 256;
   localparam int WINDOW_BITS_DEF = 64;

   localparam logic [31:0] FRESHNESS_RESET = 32'd5000;

   localparam int REQ_DATA_W = 104;
   localparam int RSP_DATA_W = 8;

   typedef enum logic {
      FUNC_CHECK  = 1'b0,
      FUNC_FORGET = 1'b1
   } func_type;

   typedef enum logic [1:0] {
      VERDICT_ACCEPT    = 2'd0,
      VERDICT_STALE     = 2'd1,
      VERDICT_REPLAY    = 2'd2,
      VERDICT_DUPLICATE = 2'd3
   } verdict_type;

endpackage

@@ src/per_peer_anti_replay_window.sv @@
// Top level of the per-peer anti-replay window filter.
//
//   channel  dir  handshake              payload
//   req_     in   req_tvalid/req_tready  tdata peer, seq, msg time, now; tuser func
//   rsp_     out  rsp_tvalid/rsp_tready  tdata verdict
//   csr_     in   csr_valid/csr_ready    csr_data freshness limit in ms
//
// The verdict becomes valid after the memory read, then update and write-back. Only one
// item is in the read/update path at a time, so no word is taken until the last one has
// left the update stage; the result register lets the next word enter while a verdict waits.
// Reset clears all peer valid flags at once; the entry memory needs no clearing.
// A stalled result holds the update stage, which holds back the input.
module per_peer_anti_replay_window
   import parw_pkg::*;
#(
   parameter int PEER_COUNT  = PEER_COUNT_DEF,
   parameter int WINDOW_BITS = WINDOW_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [7:0] peer_id, [39:8] seq_num, [71:40] msg_time_ms, [103:72] now_ms
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // [0] func
   input  logic                  req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [1:0] verdict, [7:2] zero
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [31:0]           csr_data
);

   localparam int ADDR_W = $clog2(PEER_COUNT);
   localparam int SHW    = $clog2(WINDOW_BITS);
   localparam int ENTRY_W = 32 + WINDOW_BITS;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_EXEC
   } state_type;

   state_type state_ff, state_in;

   logic [31:0] limit_ff, limit_in;
   logic [PEER_COUNT-1:0] valid_ff, valid_in;
   logic rsp_tvalid_ff, rsp_tvalid_in;
   verdict_type verdict_ff, verdict_in;

   func_type    func_ff;
   logic [7:0]  peer_ff;
   logic [31:0] seq_ff;
   logic [31:0] msg_ff;
   logic [31:0] now_ff;
   logic        stale_ff;

   logic [ENTRY_W-1:0] peer_mem [PEER_COUNT];
   logic [ENTRY_W-1:0] rd_ff;

   logic [ADDR_W-1:0] req_addr;
   logic [ADDR_W-1:0] addr;
   logic              in_range;
   logic              fire;
   logic              req_take;
   logic [31:0]       delta;
   logic              stale_in;

   logic [31:0]            high;
   logic [WINDOW_BITS-1:0] mask;
   logic [31:0]            gap;
   logic [31:0]            back;
   logic [WINDOW_BITS-1:0] back_bit;
   logic                   wr_en;
   logic [ENTRY_W-1:0]     wr_data;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_take   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W-2){1'b0}}, verdict_ff};

   assign req_addr = req_tdata[ADDR_W-1:0];
   assign addr     = peer_ff[ADDR_W-1:0];
   assign in_range = ({1'b0, peer_ff} < 9'(PEER_COUNT));
   assign fire     = (state_ff == ST_EXEC) && (!rsp_tvalid_ff || rsp_tready);

   assign delta    = (msg_ff > now_ff) ? (msg_ff - now_ff) : (now_ff - msg_ff);
   assign stale_in = (delta > limit_ff);

   assign high     = rd_ff[31:0];
   assign mask     = rd_ff[ENTRY_W-1:32];
   assign gap      = seq_ff - high;
   assign back     = high - seq_ff;
   assign back_bit = {{(WINDOW_BITS-1){1'b0}}, 1'b1} << back[SHW-1:0];

   always_comb begin
      state_in      = state_ff;
      limit_in      = limit_ff;
      valid_in      = valid_ff;
      rsp_tvalid_in = rsp_tvalid_ff;
      verdict_in    = verdict_ff;
      wr_en         = 1'b0;
      wr_data       = rd_ff;

      if (csr_valid) begin
         limit_in = csr_data;
      end
      if (rsp_tvalid_ff && rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (fire) begin
               state_in      = ST_IDLE;
               rsp_tvalid_in = 1'b1;
               verdict_in    = VERDICT_ACCEPT;
               if (func_ff == FUNC_FORGET) begin
                  if (in_range) begin
                     valid_in[addr] = 1'b0;
                  end
               end else if (stale_ff) begin
                  verdict_in = VERDICT_STALE;
               end else if (!in_range) begin
                  verdict_in = VERDICT_REPLAY;
               end else if (!valid_ff[addr]) begin
                  valid_in[addr] = 1'b1;
                  wr_en   = 1'b1;
                  wr_data = {{(WINDOW_BITS-1){1'b0}}, 1'b1, seq_ff};
               end else if (seq_ff > high) begin
                  wr_en = 1'b1;
                  if (gap >= 32'(WINDOW_BITS)) begin
                     wr_data = {{(WINDOW_BITS-1){1'b0}}, 1'b1, seq_ff};
                  end else begin
                     wr_data = {(mask << gap[SHW-1:0]) | {{(WINDOW_BITS-1){1'b0}}, 1'b1},
                                seq_ff};
                  end
               end else if (back >= 32'(WINDOW_BITS)) begin
                  verdict_in = VERDICT_REPLAY;
               end else if (mask[back[SHW-1:0]]) begin
                  verdict_in = VERDICT_DUPLICATE;
               end else begin
                  wr_en   = 1'b1;
                  wr_data = {mask | back_bit, high};
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         limit_ff      <= FRESHNESS_RESET;
         valid_ff      <= '0;
         rsp_tvalid_ff <= 1'b0;
         verdict_ff    <= VERDICT_ACCEPT;
      end else begin
         state_ff      <= state_in;
         limit_ff      <= limit_in;
         valid_ff      <= valid_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
         verdict_ff    <= verdict_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         func_ff <= func_type'(req_tuser);
         peer_ff <= req_tdata[7:0];
         seq_ff  <= req_tdata[39:8];
         msg_ff  <= req_tdata[71:40];
         now_ff  <= req_tdata[103:72];
      end
      if (state_ff == ST_READ) begin
         stale_ff <= stale_in;
      end
   end

   // entry read only on acceptance; held through the update stage
   always_ff @(posedge clock) begin
      if (req_take) begin
         rd_ff <= peer_mem[req_addr];
      end
      if (wr_en) begin
         peer_mem[addr] <= wr_data;
      end
   end

endmodule

@@ src/parw_checker.sv @@
// Port-level checker for the anti-replay window, bound to the top level.
module parw_checker
   import parw_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata
);

   logic [1:0] pending_ff, pending_in;
   logic       req_go;
   logic       rsp_go;

   assign req_go = req_tvalid && req_tready;
   assign rsp_go = rsp_tvalid && rsp_tready;

   always_comb begin
      pending_in = pending_ff;
      if (req_go && !rsp_go) begin
         pending_in = pending_ff + 2'd1;
      end else if (!req_go && rsp_go) begin
         pending_in = pending_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   a_pending_bound: assert property (@(posedge clock) disable iff (reset)
      pending_ff != 2'd3)
      else $error("more than two words in flight");

   a_rsp_has_req: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> pending_ff != 2'd0)
      else $error("response without a pending request");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

   a_rsp_pad: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[RSP_DATA_W-1:2] == '0)
      else $error("response padding not zero");

   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      pending_ff == 2'd2 |-> !req_tready)
      else $error("request taken with two words in flight");

endmodule

bind per_peer_anti_replay_window parw_checker u_parw_checker (.*);
